/* rtl/pmft_pkg.sv */
// pmft_pkg: field widths, code constants and framing bytes of the paced
// message framing transmitter
// no dependencies
package pmft_pkg;

  localparam int DATA_W    = 8;
  localparam int LEN_W     = 12;
  localparam int TIME_W    = 32;
  localparam int GAP_W     = 24;
  localparam int CNT_W     = 32;
  localparam int CFG_IDX_W = 2;

  // item kinds
  localparam logic CMD_PUSH    = 1'b0;
  localparam logic CMD_SERVICE = 1'b1;

  // pacing phase as seen on the result channel
  typedef logic [1:0] phase_t;
  localparam phase_t PH_IDLE      = 2'd0;
  localparam phase_t PH_SEND      = 2'd1;
  localparam phase_t PH_WAIT_UART = 2'd2;
  localparam phase_t PH_QUIET     = 2'd3;

  // enqueue outcome
  typedef logic [1:0] enq_stat_t;
  localparam enq_stat_t ST_NONE      = 2'd0;
  localparam enq_stat_t ST_PUBLISHED = 2'd1;
  localparam enq_stat_t ST_BAD_LEN   = 2'd2;
  localparam enq_stat_t ST_DROPPED   = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_GAP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RESET_GUARD = 2'd1;

  localparam logic [GAP_W-1:0] NORMAL_GAP_RST  = 24'd1000;
  localparam logic [GAP_W-1:0] RESET_GUARD_RST = 24'd75000;

  // framing bytes
  localparam logic [DATA_W-1:0] BYTE_C5 = 8'hc5;
  localparam logic [DATA_W-1:0] BYTE_01 = 8'h01;
  localparam logic [DATA_W-1:0] BYTE_B5 = 8'hb5;
  localparam logic [DATA_W-1:0] BYTE_A5 = 8'ha5;
  localparam logic [DATA_W-1:0] BYTE_F0 = 8'hf0;
  localparam logic [DATA_W-1:0] BYTE_F7 = 8'hf7;

endpackage

/* rtl/pmft_store.sv */
// pmft_store: byte store of the message fifo, one write and one read port,
// read data registered
// depends on pmft_pkg
module pmft_store #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [pmft_pkg::DATA_W-1:0] wr_data,
  input  logic [AW-1:0]               rd_addr,
  output logic [pmft_pkg::DATA_W-1:0] rd_data
);
  import pmft_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, read data registered
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/paced_message_framing_transmitter.sv */
// paced_message_framing_transmitter: whole-message byte fifo with a framed,
// paced uart sender; top level
// depends on pmft_pkg and pmft_store
//
// Push beats store one message byte each; a message becomes visible to the
// sender only once its last byte is in. Service beats carry the time and the
// uart flags and send at most one byte. The block works on one item at a time:
// a push goes through staging and result; a service beat through the pacing
// step, head peeks and byte send; a frame starting F0 is scanned for F7 byte
// by byte (up to SCAN_LIMIT), as every peek goes through the single read port
// of the byte store. A result waiting on a stalled output does not block the
// next accept. No clearing pass is run after reset; configuration writes are
// always taken (cfg_ready is held high) and should be made while idle.
module paced_message_framing_transmitter #(
  parameter int FIFO_DEPTH = 4096,
  parameter int SCAN_LIMIT = 256
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // item channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_cmd,
  input  logic [pmft_pkg::DATA_W-1:0]    in_data_byte,
  input  logic                           in_msg_start,
  input  logic [pmft_pkg::LEN_W-1:0]     in_msg_len,
  input  logic [pmft_pkg::TIME_W-1:0]    in_now_us,
  input  logic                           in_uart_tx_full,
  input  logic                           in_uart_tx_idle,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_tx_valid,
  output logic [pmft_pkg::DATA_W-1:0]    out_tx_byte,
  output logic [1:0]                     out_enq_status,
  output logic [pmft_pkg::LEN_W-1:0]     out_occupancy,
  output logic [pmft_pkg::CNT_W-1:0]     out_drop_total,
  output logic [1:0]                     out_pace_phase,
  // configuration
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pmft_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pmft_pkg::GAP_W-1:0]     cfg_data
);
  import pmft_pkg::*;

  localparam int PW = $clog2(FIFO_DEPTH);
  localparam int LW = (PW + 1 > 13) ? PW + 1 : 13;
  localparam int SW = ($clog2(SCAN_LIMIT + 1) > 3) ? $clog2(SCAN_LIMIT + 1) : 3;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_PUSH = 9'b000000010,
    S_SVC  = 9'b000000100,
    S_B0   = 9'b000001000,
    S_C5   = 9'b000010000,
    S_B5   = 9'b000100000,
    S_F0   = 9'b001000000,
    S_TX   = 9'b010000000,
    S_EMIT = 9'b100000000
  } ctl_state_t;

  function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
    ptr_next = (LW'(p) == LW'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PW-1:0] ofs_addr(input logic [PW-1:0] p,
                                             input logic [LW-1:0] o);
    logic [LW:0] s;
    s = (LW+1)'(p) + (LW+1)'(o);
    if (s >= (LW+1)'(FIFO_DEPTH)) s = s - (LW+1)'(FIFO_DEPTH);
    ofs_addr = s[PW-1:0];
  endfunction

  ctl_state_t state_r, state_nxt;

  // captured item
  logic              cmd_r, start_r, full_r, idle_r;
  logic [DATA_W-1:0] data_r;
  logic [LEN_W-1:0]  len_r;
  logic [TIME_W-1:0] now_r;

  // fifo and pacing state
  logic [PW-1:0]     rd_ptr_r, rd_ptr_nxt, pub_ptr_r, pub_ptr_nxt;
  logic [PW-1:0]     stg_ptr_r, stg_ptr_nxt;
  logic [LEN_W-1:0]  stg_left_r, stg_left_nxt;
  logic              stg_disc_r, stg_disc_nxt;
  logic [CNT_W-1:0]  drop_r, drop_nxt;
  phase_t            phase_r, phase_nxt;
  logic [TIME_W-1:0] deadline_r, deadline_nxt;
  logic [SW-1:0]     send_left_r, send_left_nxt;
  logic [GAP_W-1:0]  pend_gap_r, pend_gap_nxt;
  logic [GAP_W-1:0]  normal_gap_r, guard_gap_r;
  logic [SW-1:0]     scan_i_r, scan_i_nxt;

  // per-item result
  logic              res_tx_r, res_tx_nxt;
  logic [DATA_W-1:0] res_byte_r, res_byte_nxt;
  enq_stat_t         res_stat_r, res_stat_nxt;

  // output register
  logic              out_valid_r, out_tx_valid_r;
  logic [DATA_W-1:0] out_tx_byte_r;
  enq_stat_t         out_stat_r;
  logic [LEN_W-1:0]  out_occ_r;
  logic [CNT_W-1:0]  out_drop_r;
  phase_t            out_phase_r;

  // store port signals
  logic              mem_we;
  logic [PW-1:0]     mem_waddr, mem_raddr;
  logic [DATA_W-1:0] mem_rdata;

  // derived values
  logic [LW-1:0]     occ, room, len_ext, scan_lim;
  logic [TIME_W-1:0] gap_diff;
  logic [LEN_W-1:0]  left_dec;
  logic [SW-1:0]     scan_inc;
  logic              frm_go;
  logic [SW-1:0]     frm_len;
  logic [GAP_W-1:0]  frm_gap;
  logic              out_free;

  pmft_store #(.DEPTH(FIFO_DEPTH), .AW(PW)) u_store (
    .clk    (clk),
    .wr_en  (mem_we),
    .wr_addr(mem_waddr),
    .wr_data(data_r),
    .rd_addr(mem_raddr),
    .rd_data(mem_rdata)
  );

  assign occ = (pub_ptr_r >= rd_ptr_r) ? LW'(pub_ptr_r) - LW'(rd_ptr_r)
             : LW'(pub_ptr_r) + LW'(FIFO_DEPTH) - LW'(rd_ptr_r);
  assign room     = LW'(FIFO_DEPTH - 1) - occ;
  assign len_ext  = LW'(len_r);
  assign scan_lim = (occ > LW'(SCAN_LIMIT)) ? LW'(SCAN_LIMIT) : occ;
  assign gap_diff = now_r - deadline_r;
  assign left_dec = stg_left_r - 1'b1;
  assign scan_inc = scan_i_r + 1'b1;
  assign out_free = !out_valid_r || !out_stall;

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  // item sequencer: read, decide, write back
  always_comb begin
    state_nxt     = state_r;
    rd_ptr_nxt    = rd_ptr_r;
    pub_ptr_nxt   = pub_ptr_r;
    stg_ptr_nxt   = stg_ptr_r;
    stg_left_nxt  = stg_left_r;
    stg_disc_nxt  = stg_disc_r;
    drop_nxt      = drop_r;
    phase_nxt     = phase_r;
    deadline_nxt  = deadline_r;
    send_left_nxt = send_left_r;
    pend_gap_nxt  = pend_gap_r;
    scan_i_nxt    = scan_i_r;
    res_tx_nxt    = res_tx_r;
    res_byte_nxt  = res_byte_r;
    res_stat_nxt  = res_stat_r;
    mem_we        = 1'b0;
    mem_waddr     = stg_ptr_r;
    mem_raddr     = rd_ptr_r;
    frm_go        = 1'b0;
    frm_len       = '0;
    frm_gap       = normal_gap_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_cmd == CMD_SERVICE) ? S_SVC : S_PUSH;
        end
      end

      // message admission and staging
      S_PUSH: begin
        res_tx_nxt   = 1'b0;
        res_byte_nxt = '0;
        res_stat_nxt = ST_NONE;
        state_nxt    = S_EMIT;
        if (start_r) begin
          stg_left_nxt = '0;
          stg_disc_nxt = 1'b0;
          if (len_r == '0 || len_ext >= LW'(FIFO_DEPTH)) begin
            res_stat_nxt = ST_BAD_LEN;
          end else if (len_ext > room) begin
            drop_nxt     = drop_r + 1'b1;
            stg_left_nxt = len_r - 1'b1;
            stg_disc_nxt = (len_r != LEN_W'(1));
            res_stat_nxt = ST_DROPPED;
          end else begin
            mem_we       = 1'b1;
            mem_waddr    = pub_ptr_r;
            stg_ptr_nxt  = ptr_next(pub_ptr_r);
            stg_left_nxt = len_r - 1'b1;
            if (len_r == LEN_W'(1)) begin
              pub_ptr_nxt  = ptr_next(pub_ptr_r);
              res_stat_nxt = ST_PUBLISHED;
            end
          end
        end else if (stg_left_r != '0) begin
          stg_left_nxt = left_dec;
          if (stg_disc_r) begin
            if (left_dec == '0) stg_disc_nxt = 1'b0;
          end else begin
            mem_we      = 1'b1;
            stg_ptr_nxt = ptr_next(stg_ptr_r);
            if (left_dec == '0) begin
              pub_ptr_nxt  = ptr_next(stg_ptr_r);
              res_stat_nxt = ST_PUBLISHED;
            end
          end
        end
      end

      // pacing step
      S_SVC: begin
        res_tx_nxt   = 1'b0;
        res_byte_nxt = '0;
        res_stat_nxt = ST_NONE;
        state_nxt    = S_EMIT;
        case (phase_r)
          PH_WAIT_UART: begin
            if (idle_r) begin
              deadline_nxt = now_r + TIME_W'(pend_gap_r);
              phase_nxt    = PH_QUIET;
            end
          end
          PH_QUIET, PH_IDLE: begin
            if (phase_r == PH_IDLE || !gap_diff[TIME_W-1]) begin
              phase_nxt = PH_IDLE;
              if (occ != '0) state_nxt = S_B0;
            end
          end
          PH_SEND: begin
            if (send_left_r == '0) begin
              phase_nxt = PH_WAIT_UART;
            end else if (rd_ptr_r != pub_ptr_r && !full_r) begin
              state_nxt = S_TX;
            end
          end
          default: ;
        endcase
      end

      // first byte of the frame at the head
      S_B0: begin
        state_nxt = S_EMIT;
        if (mem_rdata == BYTE_C5) begin
          if (occ >= LW'(2)) begin
            mem_raddr = ofs_addr(rd_ptr_r, LW'(1));
            state_nxt = S_C5;
          end
        end else if (mem_rdata == BYTE_B5) begin
          if (occ >= LW'(4)) begin
            mem_raddr = ofs_addr(rd_ptr_r, LW'(3));
            state_nxt = S_B5;
          end else if (occ == LW'(3)) begin
            frm_go  = 1'b1;
            frm_len = SW'(3);
          end
        end else if (mem_rdata == BYTE_F0) begin
          if (scan_lim > LW'(1)) begin
            mem_raddr  = ofs_addr(rd_ptr_r, LW'(1));
            scan_i_nxt = SW'(1);
            state_nxt  = S_F0;
          end
        end else begin
          frm_go  = 1'b1;
          frm_len = SW'(1);
        end
      end

      S_C5: begin
        frm_go  = 1'b1;
        frm_len = SW'(2);
        frm_gap = (mem_rdata == BYTE_01) ? guard_gap_r : normal_gap_r;
      end

      S_B5: begin
        state_nxt = S_EMIT;
        if (mem_rdata != BYTE_A5) begin
          frm_go  = 1'b1;
          frm_len = SW'(3);
        end else if (occ >= LW'(6)) begin
          frm_go  = 1'b1;
          frm_len = SW'(6);
        end
      end

      // terminator scan, one byte a peek
      S_F0: begin
        if (mem_rdata == BYTE_F7) begin
          frm_go  = 1'b1;
          frm_len = scan_inc;
        end else begin
          scan_i_nxt = scan_inc;
          if (LW'(scan_inc) < scan_lim) begin
            mem_raddr = ofs_addr(rd_ptr_r, LW'(scan_inc));
          end else begin
            state_nxt = S_EMIT;
          end
        end
      end

      // head byte goes out
      S_TX: begin
        res_tx_nxt    = 1'b1;
        res_byte_nxt  = mem_rdata;
        rd_ptr_nxt    = ptr_next(rd_ptr_r);
        send_left_nxt = send_left_r - 1'b1;
        if (send_left_r == SW'(1)) phase_nxt = PH_WAIT_UART;
        state_nxt     = S_EMIT;
      end

      S_EMIT: begin
        if (out_free) state_nxt = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase

    // frame found: start sending, first byte re-read at the head
    if (frm_go) begin
      send_left_nxt = frm_len;
      pend_gap_nxt  = frm_gap;
      phase_nxt     = PH_SEND;
      mem_raddr     = rd_ptr_r;
      state_nxt     = full_r ? S_EMIT : S_TX;
    end
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_ptr_r    <= '0;
      pub_ptr_r   <= '0;
      stg_ptr_r   <= '0;
      stg_left_r  <= '0;
      stg_disc_r  <= 1'b0;
      drop_r      <= '0;
      phase_r     <= PH_IDLE;
      deadline_r  <= '0;
      send_left_r <= '0;
      pend_gap_r  <= NORMAL_GAP_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      pub_ptr_r   <= pub_ptr_nxt;
      stg_ptr_r   <= stg_ptr_nxt;
      stg_left_r  <= stg_left_nxt;
      stg_disc_r  <= stg_disc_nxt;
      drop_r      <= drop_nxt;
      phase_r     <= phase_nxt;
      deadline_r  <= deadline_nxt;
      send_left_r <= send_left_nxt;
      pend_gap_r  <= pend_gap_nxt;
      if (state_r == S_EMIT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      normal_gap_r <= NORMAL_GAP_RST;
      guard_gap_r  <= RESET_GUARD_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_NORMAL_GAP)  normal_gap_r <= cfg_data;
      if (cfg_index == REG_RESET_GUARD) guard_gap_r  <= cfg_data;
    end
  end

  // item capture and working payload
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      cmd_r   <= in_cmd;
      data_r  <= in_data_byte;
      start_r <= in_msg_start;
      len_r   <= in_msg_len;
      now_r   <= in_now_us;
      full_r  <= in_uart_tx_full;
      idle_r  <= in_uart_tx_idle;
    end
    scan_i_r   <= scan_i_nxt;
    res_tx_r   <= res_tx_nxt;
    res_byte_r <= res_byte_nxt;
    res_stat_r <= res_stat_nxt;
  end

  // result beat register
  always_ff @(posedge clk) begin
    if (state_r == S_EMIT && out_free) begin
      out_tx_valid_r <= res_tx_r;
      out_tx_byte_r  <= res_byte_r;
      out_stat_r     <= (cmd_r == CMD_PUSH) ? res_stat_r : ST_NONE;
      out_occ_r      <= occ[LEN_W-1:0];
      out_drop_r     <= drop_r;
      out_phase_r    <= phase_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_tx_valid   = out_tx_valid_r;
  assign out_tx_byte    = out_tx_byte_r;
  assign out_enq_status = out_stat_r;
  assign out_occupancy  = out_occ_r;
  assign out_drop_total = out_drop_r;
  assign out_pace_phase = out_phase_r;

  // published bytes never exceed the usable depth
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ <= LW'(FIFO_DEPTH - 1))
    else $error("fifo occupancy beyond depth");

  // a byte only leaves while a frame is being sent and one is published
  a_tx_state: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_TX |-> (phase_r == PH_SEND && rd_ptr_r != pub_ptr_r &&
                         send_left_r != '0))
    else $error("byte sent outside a frame");

  // a discarded message always has bytes left to count off
  a_disc_left: assert property (@(posedge clk) disable iff (!rst_n)
    stg_disc_r |-> stg_left_r != '0)
    else $error("discard flag with nothing left");

  // a sent byte is reported with the sending or uart wait phase
  a_tx_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_tx_valid |->
      (out_pace_phase == PH_SEND || out_pace_phase == PH_WAIT_UART))
    else $error("sent byte with wrong phase");

endmodule
